@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros used by the encoder top module.
// Each macro checks a property on the rising edge of clk while rst_n is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every active clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A trigger that must be followed in the next cycle by a consequence.
`define ASSERT_NEXT(label, trig, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dsre_pkg.sv @@
// ---------------------------------------------------------------------------
// dsre_pkg
// Constants of the differential syndrome redundancy encoder.
// ---------------------------------------------------------------------------
`default_nettype none

package dsre_pkg;

    // Default sizes of the encoder.
    localparam int DEF_DATA_BITS  = 16;
    localparam int DEF_RED_BITS   = 16;
    localparam int DEF_SYND_BITS  = 8;
    localparam int DEF_MAX_BLOCKS = 4;

    // Fixed field widths of the item channels.
    localparam int WORD_W = 16;
    localparam int DIFF_W = 8;
    localparam int OUT_W  = 3 * WORD_W + DIFF_W;

    // Configuration port sizes.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;

    // Layout of the block registers.
    localparam int REG_BLOCKS = 4;
    localparam int CNT_W      = 5;
    localparam int COUNTS_W   = 10;
    localparam int MASKS_W    = 32;
    localparam int OFFS_W     = 28;
    localparam int BCOUNT_W   = 3;

    // Reset value of the column count register: 15 data, 10 redundancy.
    localparam logic [COUNTS_W-1:0] COUNTS_RESET = 10'd335;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DATA_LOW    = 3'd0,
        REG_DATA_HIGH   = 3'd1,
        REG_RED_LOW     = 3'd2,
        REG_RED_HIGH    = 3'd3,
        REG_COL_COUNTS  = 3'd4,
        REG_BLOCK_MASKS = 3'd5,
        REG_BLOCK_OFFS  = 3'd6,
        REG_BLOCK_COUNT = 3'd7
    } cfg_index_t;

endpackage

`default_nettype wire

@@ rtl/differential_syndrome_redundancy_encoder_top.sv @@
// ---------------------------------------------------------------------------
// differential_syndrome_redundancy_encoder_top
// Keeps a redundancy word in step with a stream of data words by flipping
// only the redundancy bits that the syndrome difference selects.
// ---------------------------------------------------------------------------
// Usage:
//   Data words enter on the s_* stream channel; one result item per data
//   word leaves on the m_* channel carrying the data word, the updated
//   redundancy word, the flip mask and the syndrome difference.
//   The encoder has an input register and a result register. An item
//   accepted into the input register is processed there and moves into
//   the result register, which raises m_tvalid, at the next edge at which
//   the result register is free. One item is taken every cycle as long as
//   the receiver takes results; the rate is set by the single register
//   loop on the redundancy word, which is updated when an item moves from
//   the input register into the result register.
//   When the receiver stalls, the result register holds its item and the
//   input register still takes one more item, after which s_tready drops.
//   Configuration is written through cfg_we/cfg_addr/cfg_wdata while the
//   block is idle; a write takes effect at the next edge.
//   Reset (rst_n low, asynchronous) empties both registers, clears the
//   redundancy word and restores the configuration reset values.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module differential_syndrome_redundancy_encoder_top
    import dsre_pkg::*;
#(
    parameter int DATA_BITS  = DEF_DATA_BITS,
    parameter int RED_BITS   = DEF_RED_BITS,
    parameter int SYND_BITS  = DEF_SYND_BITS,
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // Configuration write port.
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

    // Input items.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [WORD_W-1:0]     s_tdata,   // [15:0] data_word

    // Result items.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_W-1:0]           m_tdata    // [15:0] data_out,
                                                  // [31:16] redundancy_word,
                                                  // [47:32] flip_mask,
                                                  // [55:48] syndrome_difference
);

    localparam int USED_BLOCKS = (MAX_BLOCKS < REG_BLOCKS) ? MAX_BLOCKS : REG_BLOCKS;
    localparam int POS_W       = 9;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] data_low_reg;
    logic [CFG_DATA_W-1:0] data_high_reg;
    logic [CFG_DATA_W-1:0] red_low_reg;
    logic [CFG_DATA_W-1:0] red_high_reg;
    logic [COUNTS_W-1:0]   counts_reg;
    logic [MASKS_W-1:0]    masks_reg;
    logic [OFFS_W-1:0]     offs_reg;
    logic [BCOUNT_W-1:0]   bcount_reg;

    // Pipeline registers and state.
    logic                  in_valid_reg;
    logic [WORD_W-1:0]     data_reg;
    logic [RED_BITS-1:0]   red_reg;
    logic [RED_BITS-1:0]   red_next;
    logic                  out_valid_reg;
    logic [OUT_W-1:0]      out_reg;
    logic [OUT_W-1:0]      out_next;

    logic                  advance;
    logic                  load;
    logic [2*CFG_DATA_W-1:0] data_cols;
    logic [2*CFG_DATA_W-1:0] red_cols;
    logic [CNT_W-1:0]      data_cnt;
    logic [CNT_W-1:0]      red_cnt;
    logic [SYND_BITS-1:0]  data_syn;
    logic [SYND_BITS-1:0]  red_syn;
    logic [SYND_BITS-1:0]  diff;
    logic [BCOUNT_W-1:0]   blocks_used;
    logic [RED_BITS-1:0]   flips;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_low_reg  <= '0;
            data_high_reg <= '0;
            red_low_reg   <= '0;
            red_high_reg  <= '0;
            counts_reg    <= COUNTS_RESET;
            masks_reg     <= '0;
            offs_reg      <= '0;
            bcount_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_addr))
                REG_DATA_LOW:    data_low_reg  <= cfg_wdata;
                REG_DATA_HIGH:   data_high_reg <= cfg_wdata;
                REG_RED_LOW:     red_low_reg   <= cfg_wdata;
                REG_RED_HIGH:    red_high_reg  <= cfg_wdata;
                REG_COL_COUNTS:  counts_reg    <= cfg_wdata[COUNTS_W-1:0];
                REG_BLOCK_MASKS: masks_reg     <= cfg_wdata[MASKS_W-1:0];
                REG_BLOCK_OFFS:  offs_reg      <= cfg_wdata[OFFS_W-1:0];
                REG_BLOCK_COUNT: bcount_reg    <= cfg_wdata[BCOUNT_W-1:0];
                default:         bcount_reg    <= bcount_reg;
            endcase
        end
    end

    // Handshake: the result register frees up when taken, the input
    // register frees up when its item moves on.
    assign advance  = !out_valid_reg || m_tready;
    assign load     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // Column counts, clamped to the matrix widths.
    always_comb
    begin
        data_cnt = counts_reg[CNT_W-1:0];
        red_cnt  = counts_reg[2*CNT_W-1:CNT_W];
        if (data_cnt > CNT_W'(DATA_BITS))
        begin
            data_cnt = CNT_W'(DATA_BITS);
        end
        if (red_cnt > CNT_W'(RED_BITS))
        begin
            red_cnt = CNT_W'(RED_BITS);
        end
    end

    assign data_cols = {data_high_reg, data_low_reg};
    assign red_cols  = {red_high_reg, red_low_reg};

    // Syndromes of the new data word and of the current redundancy word.
    always_comb
    begin
        data_syn = '0;
        red_syn  = '0;
        for (int i = 0; i < DATA_BITS; i++)
        begin
            if ((CNT_W'(i) < data_cnt) && data_reg[i])
            begin
                data_syn = data_syn ^ data_cols[i*8 +: SYND_BITS];
            end
        end
        for (int i = 0; i < RED_BITS; i++)
        begin
            if ((CNT_W'(i) < red_cnt) && red_reg[i])
            begin
                red_syn = red_syn ^ red_cols[i*8 +: SYND_BITS];
            end
        end
    end

    assign diff = data_syn ^ red_syn;

    // Block count, limited to the blocks that exist.
    always_comb
    begin
        blocks_used = bcount_reg;
        if (bcount_reg > BCOUNT_W'(USED_BLOCKS))
        begin
            blocks_used = BCOUNT_W'(USED_BLOCKS);
        end
    end

    // Each block in use with a nonzero chunk selects at most one redundancy bit to flip.
    always_comb
    begin
        logic [7:0]       chunk;
        logic [7:0]       shifted;
        logic [2:0]       bit_off;
        logic [3:0]       col_off;
        logic [POS_W-1:0] pos1;
        flips = '0;
        for (int b = 0; b < USED_BLOCKS; b++)
        begin
            chunk   = 8'(diff) & masks_reg[b*8 +: 8];
            bit_off = offs_reg[b*7 +: 3];
            col_off = offs_reg[b*7+3 +: 4];
            shifted = chunk >> bit_off;
            pos1    = POS_W'(col_off) + POS_W'(shifted);
            if ((BCOUNT_W'(b) < blocks_used) && (chunk != 8'd0))
            begin
                for (int j = 0; j < RED_BITS; j++)
                begin
                    if (pos1 == POS_W'(j + 1))
                    begin
                        flips[j] = 1'b1;
                    end
                end
            end
        end
    end

    function automatic logic [DIFF_W-1:0] diff_ext(input logic [SYND_BITS-1:0] d);
        return DIFF_W'(d);
    endfunction

    assign red_next = red_reg ^ flips;
    assign out_next = {diff_ext(diff), WORD_W'(flips), WORD_W'(red_next), data_reg};

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            data_reg <= s_tdata;
        end
    end

    // Redundancy state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                red_reg <= red_next;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= out_next;
        end
    end

    // The redundancy word only moves when an item is processed.
    `ASSERT_NEXT(a_red_stable, !load, $stable(red_reg), "redundancy changed without an item")

    // A loaded result carries the redundancy word now held in the state.
    `ASSERT_NEXT(a_red_out, load, m_tdata[2*WORD_W-1:WORD_W] == WORD_W'(red_reg),
        "result redundancy differs from state")

    // The state moved by exactly the reported flip mask.
    `ASSERT_NEXT(a_flip_mask, load,
        WORD_W'(red_reg ^ $past(red_reg)) == m_tdata[3*WORD_W-1:2*WORD_W],
        "flip mask does not match redundancy change")

endmodule

`default_nettype wire
